### src/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared constants, result type and the bytewise CRC-16 update for the
// serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rfr_pkg;

    // Payload bytes kept and reported per frame
    localparam int MaxPayload = 32;

    localparam int ByteW   = 8;
    localparam int CrcW    = 16;
    localparam int KindW   = 2;
    localparam int IndexW  = 5;
    localparam int LengthW = 6;
    localparam int CfgIdxW = 2;

    localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic [KindW-1:0] KIND_DATA    = 2'd0;
    localparam logic [KindW-1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [KindW-1:0] KIND_CRC_ERR = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_SYNC_BYTE     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_NODE_ADDRESS  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    typedef struct packed {
        logic [KindW-1:0]   result_kind;
        logic [ByteW-1:0]   data_byte;
        logic [IndexW-1:0]  data_index;
        logic [ByteW-1:0]   command_code;
        logic [LengthW-1:0] data_length;
        logic               address_match;
    } result_t;

    // CRC-16 XMODEM, one byte, MSB first
    function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
        logic [CrcW-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < ByteW; i++) begin
            if (c[CrcW-1])
                c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
            else
                c = {c[CrcW-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/rfr_ifs.sv
// ----------------------------------------------------------------------------
// rfr interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfr_in_if
    import rfr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [ByteW-1:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface rfr_out_if
    import rfr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KindW-1:0]   result_kind;
    logic [ByteW-1:0]   data_byte;
    logic [IndexW-1:0]  data_index;
    logic [ByteW-1:0]   command_code;
    logic [LengthW-1:0] data_length;
    logic               address_match;

    modport source (output valid, output result_kind, output data_byte,
                    output data_index, output command_code, output data_length,
                    output address_match, input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input data_index, input command_code, input data_length,
                    input address_match, output ready);
endinterface

interface rfr_cfg_if
    import rfr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [ByteW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/rfr_frame_core.sv
// ----------------------------------------------------------------------------
// rfr_frame_core
// Frame state, running CRC, idle timer and configuration registers. Each
// accepted item updates the state in the same cycle and may raise a result.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_frame_core
    import rfr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    rfr_cfg_if.sink               cfg,
    input  wire logic             item_fire,
    input  wire logic             opcode,
    input  wire logic [ByteW-1:0] rx_byte,
    output      logic             res_valid,
    output      result_t          res
);

    localparam logic [2:0] ST_SYNC  = 3'd0;
    localparam logic [2:0] ST_ADDR  = 3'd1;
    localparam logic [2:0] ST_CMD   = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_CRCHI = 3'd5;
    localparam logic [2:0] ST_CRCLO = 3'd6;

    localparam logic [ByteW-1:0] MaxCount = ByteW'(MaxPayload);
    localparam logic [ByteW-1:0] IdleMax  = '1;

    logic [ByteW-1:0] sync_byte_reg, node_address_reg, timeout_ticks_reg;

    logic [2:0]       state_reg, state_next;
    logic             addr_hit_reg, addr_hit_next;
    logic [ByteW-1:0] command_reg, command_next;
    logic [ByteW-1:0] decl_len_reg, decl_len_next;
    logic [ByteW-1:0] count_reg, count_next;
    logic [CrcW-1:0]  crc_reg, crc_next;
    logic [ByteW-1:0] crc_hi_reg, crc_hi_next;
    logic [ByteW-1:0] idle_reg, idle_next;

    logic [CrcW-1:0]  crc_upd;
    logic [ByteW-1:0] count_inc;
    logic [ByteW-1:0] idle_inc;
    logic [ByteW-1:0] len_clamped;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sync_byte_reg     <= '0;
            node_address_reg  <= '0;
            timeout_ticks_reg <= ByteW'(1);
        end else if (cfg.valid) begin
            unique case (cfg.index)
                CFG_SYNC_BYTE:     sync_byte_reg     <= cfg.data;
                CFG_NODE_ADDRESS:  node_address_reg  <= cfg.data;
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg.data;
                default:           ;
            endcase
        end
    end

    // CRC seeds from zero on the sync byte
    assign crc_upd     = crc16_byte((state_reg == ST_SYNC) ? '0 : crc_reg, rx_byte);
    assign count_inc   = count_reg + ByteW'(1);
    assign idle_inc    = (idle_reg == IdleMax) ? idle_reg : idle_reg + ByteW'(1);
    assign len_clamped = (count_reg > MaxCount) ? MaxCount : count_reg;

    // Next state and result
    always_comb begin
        state_next    = state_reg;
        addr_hit_next = addr_hit_reg;
        command_next  = command_reg;
        decl_len_next = decl_len_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_hi_next   = crc_hi_reg;
        idle_next     = idle_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (item_fire) begin
            if (opcode == OP_TICK) begin
                if (state_reg != ST_SYNC) begin
                    idle_next = idle_inc;
                    if (idle_inc >= timeout_ticks_reg) begin
                        state_next = ST_SYNC;
                        idle_next  = '0;
                    end
                end
            end else begin
                idle_next = '0;
                unique case (state_reg)
                    ST_SYNC: begin
                        if (rx_byte == sync_byte_reg) begin
                            crc_next   = crc_upd;
                            state_next = ST_ADDR;
                        end
                    end
                    ST_ADDR: begin
                        crc_next      = crc_upd;
                        addr_hit_next = (rx_byte == node_address_reg);
                        state_next    = ST_CMD;
                    end
                    ST_CMD: begin
                        crc_next     = crc_upd;
                        command_next = rx_byte;
                        state_next   = ST_LEN;
                    end
                    ST_LEN: begin
                        crc_next      = crc_upd;
                        decl_len_next = rx_byte;
                        count_next    = '0;
                        state_next    = (rx_byte == '0) ? ST_CRCHI : ST_DATA;
                    end
                    ST_DATA: begin
                        crc_next   = crc_upd;
                        count_next = count_inc;
                        if (count_reg < MaxCount) begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_DATA;
                            res.data_byte   = rx_byte;
                            res.data_index  = count_reg[IndexW-1:0];
                        end
                        if (count_inc == decl_len_reg)
                            state_next = ST_CRCHI;
                    end
                    ST_CRCHI: begin
                        crc_hi_next = rx_byte;
                        state_next  = ST_CRCLO;
                    end
                    ST_CRCLO: begin
                        res_valid         = 1'b1;
                        res.result_kind   = ((crc_hi_reg == crc_reg[CrcW-1:ByteW]) &&
                                             (rx_byte == crc_reg[ByteW-1:0]))
                                            ? KIND_ACCEPT : KIND_CRC_ERR;
                        res.command_code  = command_reg;
                        res.data_length   = len_clamped[LengthW-1:0];
                        res.address_match = addr_hit_reg;
                        state_next        = ST_SYNC;
                    end
                    default: state_next = ST_SYNC;
                endcase
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= ST_SYNC;
            addr_hit_reg <= 1'b0;
            command_reg  <= '0;
            decl_len_reg <= '0;
            count_reg    <= '0;
            crc_reg      <= '0;
            crc_hi_reg   <= '0;
            idle_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            addr_hit_reg <= addr_hit_next;
            command_reg  <= command_next;
            decl_len_reg <= decl_len_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_hi_reg   <= crc_hi_next;
            idle_reg     <= idle_next;
        end
    end

endmodule

`default_nettype wire

### src/rfr_out_buffer.sv
// ----------------------------------------------------------------------------
// rfr_out_buffer
// Result register with one skid entry, so an item can still be taken in the
// cycle the downstream side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_out_buffer
    import rfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output      logic    can_accept,
    rfr_out_if.source    result
);

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    pop;

    assign pop        = out_valid_reg && result.ready;
    assign can_accept = !skid_valid_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (!out_valid_reg || pop)
                out_valid_reg  <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk) begin
        if (skid_valid_reg) begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end else if (push) begin
            if (!out_valid_reg || pop)
                out_data_reg  <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.result_kind   = out_data_reg.result_kind;
    assign result.data_byte     = out_data_reg.data_byte;
    assign result.data_index    = out_data_reg.data_index;
    assign result.command_code  = out_data_reg.command_code;
    assign result.data_length   = out_data_reg.data_length;
    assign result.address_match = out_data_reg.address_match;

endmodule

`default_nettype wire

### src/rs485_frame_receiver_crc16.sv
// ----------------------------------------------------------------------------
// rs485_frame_receiver_crc16
// Serial frame receiver: sync, address, command, length, data, CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   rx     - input items: opcode 0 carries a received byte in rx_byte,
//            opcode 1 is one time tick.
//   result - one item per stored payload byte (kind 0, with index) and one
//            per completed frame (kind 1 accepted, kind 2 CRC error), with
//            command, clamped length and address match.
//   cfg    - register writes: 0 sync byte, 1 node address, 2 timeout ticks.
//            Always ready; write only while no item is in flight.
// Throughput is one item per clock while rx.ready is high: the bytewise CRC
// and frame state update complete in the cycle an item is accepted. A result
// is registered in the output buffer before it is valid on the result channel.
// Reset clears the frame state, CRC and idle timer; registers return to
// sync 0, address 0, timeout 1. When the result side stalls, one further
// result is held in a skid entry and rx.ready drops until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module rs485_frame_receiver_crc16
    import rfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rfr_in_if.sink    rx,
    rfr_out_if.source result,
    rfr_cfg_if.sink   cfg
);

    logic    can_accept;
    logic    item_fire;
    logic    res_valid;
    result_t res;

    assign rx.ready  = can_accept;
    assign item_fire = rx.valid && can_accept;

    rfr_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_fire (item_fire),
        .opcode    (rx.opcode),
        .rx_byte   (rx.rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    rfr_out_buffer u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (can_accept),
        .result     (result)
    );

endmodule

`default_nettype wire
